>>> hdl/lfpd_pkg.sv
// Shared types and constants for the line-follower PD steering block.
package lfpd_pkg;

    localparam int PATTERN_W = 7;
    localparam int ERROR_W   = 8;
    localparam int RPM_W     = 15;
    localparam int REF_W     = 9;
    localparam int GAIN_W    = 8;
    localparam int LEVEL_W   = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 9;

    localparam int RPM_FLOOR = 17;
    localparam int RPM_CEIL  = 32767;

    localparam logic [PATTERN_W-1:0] PAT_CENTER = 7'h63;
    localparam logic [PATTERN_W-1:0] PAT_POS1   = 7'h67;
    localparam logic [PATTERN_W-1:0] PAT_NEG1   = 7'h73;
    localparam logic [PATTERN_W-1:0] PAT_POS2   = 7'h47;
    localparam logic [PATTERN_W-1:0] PAT_NEG2   = 7'h71;
    localparam logic [PATTERN_W-1:0] PAT_POS3   = 7'h4F;
    localparam logic [PATTERN_W-1:0] PAT_NEG3   = 7'h79;
    localparam logic [PATTERN_W-1:0] PAT_POS4   = 7'h0F;
    localparam logic [PATTERN_W-1:0] PAT_NEG4   = 7'h78;
    localparam logic [PATTERN_W-1:0] PAT_POS5   = 7'h1F;
    localparam logic [PATTERN_W-1:0] PAT_NEG5   = 7'h7C;
    localparam logic [PATTERN_W-1:0] PAT_POS6   = 7'h3F;
    localparam logic [PATTERN_W-1:0] PAT_NEG6   = 7'h7E;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEER_ENABLE = 3'd0,
        CFG_REF_RPM      = 3'd1,
        CFG_GAIN_P       = 3'd2,
        CFG_GAIN_D       = 3'd3,
        CFG_ERR_LEVEL4   = 3'd4,
        CFG_ERR_LEVEL5   = 3'd5,
        CFG_ERR_LEVEL6   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic                     steer_enable;
        logic [REF_W-1:0]         ref_rpm;
        logic [GAIN_W-1:0]        gain_p;
        logic [GAIN_W-1:0]        gain_d;
        logic [LEVEL_W-1:0]       err_level4;
        logic [LEVEL_W-1:0]       err_level5;
        logic [LEVEL_W-1:0]       err_level6;
    } cfg_regs_t;

    typedef struct packed {
        logic                        found;
        logic signed [ERROR_W-1:0]   error;
    } err_map_t;

endpackage

>>> hdl/lfpd_err_map.sv
// Sensor pattern decoder that maps known patterns to a signed line error.
module lfpd_err_map
    import lfpd_pkg::*;
(
    input  logic [PATTERN_W-1:0] pattern,
    input  cfg_regs_t            cfg,
    output err_map_t             result
);

    logic signed [ERROR_W-1:0] lvl4;
    logic signed [ERROR_W-1:0] lvl5;
    logic signed [ERROR_W-1:0] lvl6;

    assign lvl4 = $signed({1'b0, cfg.err_level4});
    assign lvl5 = $signed({1'b0, cfg.err_level5});
    assign lvl6 = $signed({1'b0, cfg.err_level6});

    always_comb begin
        result.found = 1'b1;
        unique case (pattern)
            PAT_CENTER: result.error = 8'sd0;
            PAT_POS1:   result.error = 8'sd1;
            PAT_NEG1:   result.error = -8'sd1;
            PAT_POS2:   result.error = 8'sd2;
            PAT_NEG2:   result.error = -8'sd2;
            PAT_POS3:   result.error = 8'sd3;
            PAT_NEG3:   result.error = -8'sd3;
            PAT_POS4:   result.error = lvl4;
            PAT_NEG4:   result.error = -lvl4;
            PAT_POS5:   result.error = lvl5;
            PAT_NEG5:   result.error = -lvl5;
            PAT_POS6:   result.error = lvl6;
            PAT_NEG6:   result.error = -lvl6;
            default: begin
                result.found = 1'b0;
                result.error = 8'sd0;
            end
        endcase
    end

endmodule

>>> hdl/lfpd_pd_calc.sv
// PD correction and clamped wheel speed computation.
module lfpd_pd_calc
    import lfpd_pkg::*;
(
    input  cfg_regs_t                 cfg,
    input  logic signed [ERROR_W-1:0] error,
    input  logic signed [ERROR_W-1:0] prev_error,
    output logic [RPM_W-1:0]          left_rpm,
    output logic [RPM_W-1:0]          right_rpm
);

    localparam int PTERM_W = ERROR_W + GAIN_W + 1;
    localparam int DTERM_W = ERROR_W + GAIN_W + 2;
    localparam int PID_W   = DTERM_W + 1;

    logic signed [ERROR_W:0]   diff;
    logic signed [PTERM_W-1:0] err_ext;
    logic signed [PTERM_W-1:0] gp_ext;
    logic signed [PTERM_W-1:0] pterm;
    logic signed [DTERM_W-1:0] diff_ext;
    logic signed [DTERM_W-1:0] gd_ext;
    logic signed [DTERM_W-1:0] dprod;
    logic signed [DTERM_W-1:0] dterm;
    logic signed [PID_W-1:0]   pid;
    logic signed [PID_W-1:0]   ref_ext;
    logic signed [PID_W-1:0]   left_raw;
    logic signed [PID_W-1:0]   right_raw;

    function automatic logic [RPM_W-1:0] clamp_rpm(input logic signed [PID_W-1:0] v);
        logic [RPM_W-1:0] r;
        if (v < PID_W'(RPM_FLOOR)) begin
            r = RPM_W'(RPM_FLOOR);
        end else if (v > PID_W'(RPM_CEIL)) begin
            r = RPM_W'(RPM_CEIL);
        end else begin
            r = v[RPM_W-1:0];
        end
        return r;
    endfunction

    assign diff     = {error[ERROR_W-1], error} - {prev_error[ERROR_W-1], prev_error};
    assign err_ext  = PTERM_W'(error);
    assign gp_ext   = $signed({{(PTERM_W-GAIN_W){1'b0}}, cfg.gain_p});
    assign pterm    = err_ext * gp_ext;
    assign diff_ext = DTERM_W'(diff);
    assign gd_ext   = $signed({{(DTERM_W-GAIN_W){1'b0}}, cfg.gain_d});
    assign dprod    = diff_ext * gd_ext;

    // An arithmetic shift rounds toward minus infinity, so negative products are bumped first to halve toward zero.
    assign dterm = (dprod + $signed({{(DTERM_W-1){1'b0}}, dprod[DTERM_W-1]})) >>> 1;

    assign pid       = PID_W'(pterm) + PID_W'(dterm);
    assign ref_ext   = $signed({{(PID_W-REF_W){1'b0}}, cfg.ref_rpm});
    assign left_raw  = ref_ext - pid;
    assign right_raw = ref_ext + pid;

    always_comb begin
        if (cfg.steer_enable) begin
            left_rpm  = clamp_rpm(left_raw);
            right_rpm = clamp_rpm(right_raw);
        end else begin
            left_rpm  = {{(RPM_W-REF_W){1'b0}}, cfg.ref_rpm};
            right_rpm = {{(RPM_W-REF_W){1'b0}}, cfg.ref_rpm};
        end
    end

endmodule

>>> hdl/line_follow_pd_steering.sv
// Top level of the line-follower PD steering block.
//
//   Channel   Direction  Transfer when         Payload
//   s_        in         s_valid & s_ready     s_sensor_pattern
//   m_        out        m_valid & m_ready     m_left_rpm, m_right_rpm, m_line_error
//   cfg_      in         cfg_wr_en             cfg_addr, cfg_wdata
//
// A sample is held in the input register and is decoded and steered on its way into the
// result register, from which its result is presented.
// One sample is accepted every cycle while m_ready is high; the result register and
// input register together hold two items when the output stalls.
// Synchronous active-low reset empties both registers and restores register defaults.
module line_follow_pd_steering
    import lfpd_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [PATTERN_W-1:0]      s_sensor_pattern,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [RPM_W-1:0]          m_left_rpm,
    output logic [RPM_W-1:0]          m_right_rpm,
    output logic signed [ERROR_W-1:0] m_line_error,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_addr,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata
);

    cfg_regs_t                 cfg_reg;
    logic                      s1_valid_reg;
    logic [PATTERN_W-1:0]      s1_pattern_reg;
    logic signed [ERROR_W-1:0] held_error_reg;
    logic signed [ERROR_W-1:0] prev_error_reg;
    logic signed [ERROR_W-1:0] held_error_next;
    logic signed [ERROR_W-1:0] prev_error_next;
    logic                      m_valid_reg;
    logic [RPM_W-1:0]          left_reg;
    logic [RPM_W-1:0]          right_reg;
    logic signed [ERROR_W-1:0] line_error_reg;
    logic [RPM_W-1:0]          left_next;
    logic [RPM_W-1:0]          right_next;
    logic                      s1_advance;
    err_map_t                  map_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.steer_enable <= 1'b0;
            cfg_reg.ref_rpm      <= 9'd129;
            cfg_reg.gain_p       <= 8'd24;
            cfg_reg.gain_d       <= 8'd0;
            cfg_reg.err_level4   <= 7'd6;
            cfg_reg.err_level5   <= 7'd9;
            cfg_reg.err_level6   <= 7'd11;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_STEER_ENABLE: cfg_reg.steer_enable <= cfg_wdata[0];
                CFG_REF_RPM:      cfg_reg.ref_rpm      <= cfg_wdata[REF_W-1:0];
                CFG_GAIN_P:       cfg_reg.gain_p       <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN_D:       cfg_reg.gain_d       <= cfg_wdata[GAIN_W-1:0];
                CFG_ERR_LEVEL4:   cfg_reg.err_level4   <= cfg_wdata[LEVEL_W-1:0];
                CFG_ERR_LEVEL5:   cfg_reg.err_level5   <= cfg_wdata[LEVEL_W-1:0];
                CFG_ERR_LEVEL6:   cfg_reg.err_level6   <= cfg_wdata[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;

    lfpd_err_map u_err_map (
        .pattern (s1_pattern_reg),
        .cfg     (cfg_reg),
        .result  (map_res)
    );

    assign held_error_next = map_res.found ? map_res.error : held_error_reg;
    assign prev_error_next = cfg_reg.steer_enable ? held_error_next : prev_error_reg;

    lfpd_pd_calc u_pd_calc (
        .cfg        (cfg_reg),
        .error      (held_error_next),
        .prev_error (prev_error_reg),
        .left_rpm   (left_next),
        .right_rpm  (right_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            held_error_reg <= '0;
            prev_error_reg <= '0;
        end else begin
            if (s_valid && s_ready) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance) begin
                m_valid_reg    <= 1'b1;
                held_error_reg <= held_error_next;
                prev_error_reg <= prev_error_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_pattern_reg <= s_sensor_pattern;
        end
        if (s1_advance) begin
            left_reg       <= left_next;
            right_reg      <= right_next;
            line_error_reg <= held_error_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_left_rpm   = left_reg;
    assign m_right_rpm  = right_reg;
    assign m_line_error = line_error_reg;

    // A buffered sample must wait while the result register is stalled.
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while both stages are full");

    // Every sample leaving the input register produces a result.
    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_advance |=> m_valid)
        else $error("result missing after stage advance");

    // The previous error only moves when a sample is steered.
    a_prev_error_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_advance |=> $stable(prev_error_reg))
        else $error("previous error changed without a sample");

    // Steered speeds are clamped; unsteered speeds are equal.
    a_speed_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_left_rpm >= RPM_W'(RPM_FLOOR) && m_right_rpm >= RPM_W'(RPM_FLOOR))
                     || m_left_rpm == m_right_rpm))
        else $error("wheel speed below floor");

endmodule

>>> tb/line_follow_pd_steering_tb.sv
// Self-checking testbench for the line-follower PD steering block with a built-in wheel predictor.
module line_follow_pd_steering_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lfpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD      = 80;
    localparam int PHASE_SAMPLES  = 80;

    localparam logic [PATTERN_W-1:0] TRACK_PATTERNS [13] = '{
        PAT_CENTER, PAT_POS1, PAT_NEG1, PAT_POS2, PAT_NEG2, PAT_POS3, PAT_NEG3,
        PAT_POS4, PAT_NEG4, PAT_POS5, PAT_NEG5, PAT_POS6, PAT_NEG6
    };

    typedef struct {
        logic [RPM_W-1:0]          left;
        logic [RPM_W-1:0]          right;
        logic signed [ERROR_W-1:0] error;
    } wheel_cmd_t;

    class steering_scoreboard;
        bit                        steer_on;
        logic [REF_W-1:0]          base_rpm;
        logic [GAIN_W-1:0]         kp;
        logic [GAIN_W-1:0]         kd;
        logic [LEVEL_W-1:0]        level4;
        logic [LEVEL_W-1:0]        level5;
        logic [LEVEL_W-1:0]        level6;
        logic signed [ERROR_W-1:0] held_error;
        logic signed [ERROR_W-1:0] prior_error;
        wheel_cmd_t                expected_cmds [$];
        int                        failures;

        function new();
            steer_on    = 1'b0;
            base_rpm    = 129;
            kp          = 24;
            kd          = 0;
            level4      = 6;
            level5      = 9;
            level6      = 11;
            held_error  = '0;
            prior_error = '0;
            failures    = 0;
        endfunction

        function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_STEER_ENABLE: steer_on = value[0];
                CFG_REF_RPM:      base_rpm = value[REF_W-1:0];
                CFG_GAIN_P:       kp = value[GAIN_W-1:0];
                CFG_GAIN_D:       kd = value[GAIN_W-1:0];
                CFG_ERR_LEVEL4:   level4 = value[LEVEL_W-1:0];
                CFG_ERR_LEVEL5:   level5 = value[LEVEL_W-1:0];
                CFG_ERR_LEVEL6:   level6 = value[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        function int clamp_speed(int speed);
            if (speed < RPM_FLOOR) return RPM_FLOOR;
            if (speed > RPM_CEIL) return RPM_CEIL;
            return speed;
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction

        function void note_sample(logic [PATTERN_W-1:0] pattern);
            logic signed [ERROR_W-1:0] mapped;
            bit                        known;
            int                        correction;
            wheel_cmd_t                cmd;
            known  = 1'b1;
            mapped = '0;
            case (pattern)
                PAT_CENTER: mapped = 8'sd0;
                PAT_POS1:   mapped = 8'sd1;
                PAT_NEG1:   mapped = -8'sd1;
                PAT_POS2:   mapped = 8'sd2;
                PAT_NEG2:   mapped = -8'sd2;
                PAT_POS3:   mapped = 8'sd3;
                PAT_NEG3:   mapped = -8'sd3;
                PAT_POS4:   mapped = $signed({1'b0, level4});
                PAT_NEG4:   mapped = -$signed({1'b0, level4});
                PAT_POS5:   mapped = $signed({1'b0, level5});
                PAT_NEG5:   mapped = -$signed({1'b0, level5});
                PAT_POS6:   mapped = $signed({1'b0, level6});
                PAT_NEG6:   mapped = -$signed({1'b0, level6});
                default:    known = 1'b0;
            endcase
            if (known) held_error = mapped;
            if (steer_on) begin
                // Integer division truncates toward zero, as the derivative halving requires.
                correction = int'(held_error) * int'(kp)
                    + ((int'(held_error) - int'(prior_error)) * int'(kd)) / 2;
                cmd.left    = RPM_W'(clamp_speed(int'(base_rpm) - correction));
                cmd.right   = RPM_W'(clamp_speed(int'(base_rpm) + correction));
                prior_error = held_error;
            end else begin
                cmd.left  = RPM_W'(base_rpm);
                cmd.right = RPM_W'(base_rpm);
            end
            cmd.error = held_error;
            expected_cmds.push_back(cmd);
        endfunction

        function void check_command(logic [RPM_W-1:0] left, logic [RPM_W-1:0] right,
                                    logic signed [ERROR_W-1:0] error);
            wheel_cmd_t cmd;
            if (expected_cmds.size() == 0) begin
                $display("%0t: unexpected result left_rpm=%0d right_rpm=%0d line_error=%0d",
                         $time, left, right, error);
                failures++;
                return;
            end
            cmd = expected_cmds.pop_front();
            if (left !== cmd.left) begin
                $display("%0t: left_rpm expected %0d, actual %0d", $time, cmd.left, left);
                failures++;
            end
            if (right !== cmd.right) begin
                $display("%0t: right_rpm expected %0d, actual %0d", $time, cmd.right, right);
                failures++;
            end
            if (error !== cmd.error) begin
                $display("%0t: line_error expected %0d, actual %0d", $time, cmd.error, error);
                failures++;
            end
        endfunction

        function void report_leftover();
            if (expected_cmds.size() != 0) begin
                $display("%0t: %0d expected results never arrived", $time, expected_cmds.size());
                failures += expected_cmds.size();
            end
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [PATTERN_W-1:0]      s_sensor_pattern;
    logic                      m_valid;
    logic                      m_ready;
    logic [RPM_W-1:0]          m_left_rpm;
    logic [RPM_W-1:0]          m_right_rpm;
    logic signed [ERROR_W-1:0] m_line_error;
    logic                      cfg_wr_en;
    logic [CFG_IDX_W-1:0]      cfg_addr;
    logic [CFG_DATA_W-1:0]     cfg_wdata;

    steering_scoreboard sb;
    bit                 no_idle;
    int                 hold_epoch;
    int                 quiet_cycles;

    line_follow_pd_steering DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sensor_pattern (s_sensor_pattern),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_rpm       (m_left_rpm),
        .m_right_rpm      (m_right_rpm),
        .m_line_error     (m_line_error),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int pick_setting(int hi);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return hi;
            default: return $urandom_range(0, hi);
        endcase
    endfunction

    function automatic logic [PATTERN_W-1:0] pick_pattern();
        if ($urandom_range(0, 3) != 0) return TRACK_PATTERNS[$urandom_range(0, 12)];
        return PATTERN_W'($urandom_range(0, 127));
    endfunction

    task automatic send_sample(input logic [PATTERN_W-1:0] pattern);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_sensor_pattern <= pattern;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_register(idx, CFG_DATA_W'(value));
    endtask

    task automatic apply_settings(input int enable, input int base, input int gp, input int gd,
                                  input int lvl4, input int lvl5, input int lvl6);
        drain();
        write_register(CFG_STEER_ENABLE, enable);
        write_register(CFG_REF_RPM, base);
        write_register(CFG_GAIN_P, gp);
        write_register(CFG_GAIN_D, gd);
        write_register(CFG_ERR_LEVEL4, lvl4);
        write_register(CFG_ERR_LEVEL5, lvl5);
        write_register(CFG_ERR_LEVEL6, lvl6);
    endtask

    initial begin : receiver
        int stall;
        int seen_epoch;
        seen_epoch = 0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_epoch != seen_epoch) begin
                seen_epoch = hold_epoch;
                stall = LONG_HOLD;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 9);
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_command(m_left_rpm, m_right_rpm, m_line_error);
            if (s_valid && s_ready) sb.note_sample(s_sensor_pattern);
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL line_follow_pd_steering");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int phase;
        int n;
        s_valid          = 1'b0;
        s_sensor_pattern = '0;
        m_ready          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_addr         = CFG_STEER_ENABLE;
        cfg_wdata        = '0;
        aresetn          = 1'b0;
        no_idle          = 1'b0;
        hold_epoch       = 0;
        quiet_cycles     = 0;
        sb               = new();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset defaults with steering off: all-line, no-line, then every known pattern.
        send_sample(7'h00);
        send_sample(7'h7F);
        foreach (TRACK_PATTERNS[i]) send_sample(TRACK_PATTERNS[i]);

        // Largest gains and error levels drive both wheels into the floor and the ceiling.
        apply_settings(1, 510, 255, 255, 127, 127, 127);
        send_sample(PAT_POS6);
        send_sample(PAT_NEG6);
        send_sample(7'h00);
        send_sample(PAT_CENTER);
        send_sample(PAT_NEG1);
        send_sample(PAT_POS1);

        for (phase = 0; phase < 10; phase++) begin
            case (phase)
                1: apply_settings(1, 0, 255, 255, 127, 127, 127);
                2: apply_settings(0, $urandom_range(0, 16), pick_setting(255),
                                  pick_setting(255), pick_setting(127), pick_setting(127),
                                  pick_setting(127));
                5: apply_settings(1, 510, 0, 0, 0, 0, 0);
                default: apply_settings($urandom_range(0, 4) != 0, pick_setting(510),
                                        pick_setting(255), pick_setting(255),
                                        pick_setting(127), pick_setting(127),
                                        pick_setting(127));
            endcase
            no_idle = (phase % 4 == 0);
            if (phase == 0) hold_epoch++;
            for (n = 0; n < PHASE_SAMPLES; n++) begin
                if (n == PHASE_SAMPLES / 2 && phase % 3 == 1) drain();
                send_sample(pick_pattern());
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        sb.report_leftover();
        if (sb.failures == 0) begin
            $display("PASS line_follow_pd_steering");
        end else begin
            $display("FAIL line_follow_pd_steering");
        end
        $finish;
    end

endmodule
